[design/rgbtp_pkg.sv]
// rgbtp_pkg: shared types, character codes and limits for the rgb triple text parser
// no dependencies
package rgbtp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned AccW   = 9;
  localparam int unsigned ColW   = 24;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned SumW   = 12;

  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChComma = 8'h2c;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChCr    = 8'h0d;

  localparam logic [AccW-1:0] ValueMax = 9'd255;
  localparam logic [AccW-1:0] AccSat   = 9'd256;
  localparam logic [IdxW-1:0] LastIdx  = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_LEAD   = 2'd1,
    MODE_AFTER  = 2'd2,
    MODE_NUMBER = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [IdxW-1:0]  idx;
    logic [AccW-1:0]  acc;
    logic [ColW-1:0]  col;
  } parse_st_t;

  typedef struct packed {
    logic            emit;
    logic            ok;
    logic [ColW-1:0] colour;
  } parse_res_t;

endpackage

[design/rgb_triple_text_parser_unit.sv]
// a character that ends a parse goes from the input register through the parse step into the result register
// throughput: one character per cycle; the input register advances whenever the
// result register is empty or being drained, set by the parse state feedback loop
// reset: synchronous active-low rst_n clears valids and returns the parser to idle
// rgb_triple_text_parser_unit: input register, parse step, result register
// depends on rgbtp_pkg and rgbtp_step
module rgb_triple_text_parser_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rgbtp_pkg::CharW-1:0]   in_char_code,
  input  logic                          in_start_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ok,
  output logic [rgbtp_pkg::ColW-1:0]    out_colour
);

  logic                         in_vld_r;
  logic [rgbtp_pkg::CharW-1:0]  char_r;
  logic                         start_r;
  rgbtp_pkg::parse_st_t         st_r;
  rgbtp_pkg::parse_st_t         st_nxt;
  rgbtp_pkg::parse_res_t        res;
  logic                         out_vld_r;
  logic                         ok_r;
  logic [rgbtp_pkg::ColW-1:0]   colour_r;
  logic                         advance;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  rgbtp_step u_step (
    .cur       (st_r),
    .char_code (char_r),
    .start_req (start_r),
    .nxt       (st_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r.mode <= rgbtp_pkg::MODE_IDLE;
      st_r.idx  <= '0;
      st_r.acc  <= '0;
      st_r.col  <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
      if (advance && res.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      char_r  <= in_char_code;
      start_r <= in_start_req;
    end
    if (advance && res.emit) begin
      ok_r     <= res.ok;
      colour_r <= res.colour;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_ok     = ok_r;
  assign out_colour = colour_r;

  // stall only when the result register is full and held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && out_vld_r && !out_ready))
    else $error("input stalled without a held result");

  // a finished parse leaves the parser idle
  a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.emit) |=> (st_r.mode == rgbtp_pkg::MODE_IDLE))
    else $error("parser not idle after result");

  // success only on the third number, or on a character without a start request
  a_ok_on_third: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.emit && res.ok) |-> (st_r.idx == rgbtp_pkg::LastIdx || start_r == 1'b0))
    else $error("success before third number");

  // accumulator saturates and index stays in range
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.acc <= rgbtp_pkg::AccSat) && (st_r.idx != 2'd3))
    else $error("accumulator or field index out of range");

endmodule

[design/rgbtp_step.sv]
// rgbtp_step: per-character parse step, current state and character in, next state and result out
// depends on rgbtp_pkg
module rgbtp_step (
  input  rgbtp_pkg::parse_st_t            cur,
  input  logic [rgbtp_pkg::CharW-1:0]     char_code,
  input  logic                            start_req,
  output rgbtp_pkg::parse_st_t            nxt,
  output rgbtp_pkg::parse_res_t           res
);

  rgbtp_pkg::parse_st_t          st;
  logic                          is_digit;
  logic                          is_space;
  logic [rgbtp_pkg::AccW-1:0]    digit;
  logic [rgbtp_pkg::SumW-1:0]    sum;
  logic [rgbtp_pkg::ColW-1:0]    packed_col;

  assign is_digit = (char_code >= rgbtp_pkg::ChZero) && (char_code <= rgbtp_pkg::ChNine);
  assign is_space = (char_code == rgbtp_pkg::ChSpace) ||
                    ((char_code >= rgbtp_pkg::ChTab) && (char_code <= rgbtp_pkg::ChCr));
  assign digit    = {5'd0, char_code[3:0]};

  always_comb begin
    st = cur;
    if (start_req) begin
      st.mode = rgbtp_pkg::MODE_LEAD;
      st.idx  = '0;
      st.acc  = '0;
      st.col  = '0;
    end
  end

  // times ten plus digit
  assign sum        = {st.acc, 3'b000} + {2'b00, st.acc, 1'b0} + {3'b000, digit};
  assign packed_col = {st.col[rgbtp_pkg::ColW-9:0], st.acc[7:0]};

  always_comb begin
    nxt        = st;
    res.emit   = 1'b0;
    res.ok     = 1'b0;
    res.colour = st.col;
    unique case (st.mode)
      rgbtp_pkg::MODE_LEAD, rgbtp_pkg::MODE_AFTER: begin
        if ((st.mode == rgbtp_pkg::MODE_LEAD) && is_space) begin
          nxt = st;
        end else if (!is_digit) begin
          res.emit = 1'b1;
          nxt.mode = rgbtp_pkg::MODE_IDLE;
        end else begin
          nxt.acc  = digit;
          nxt.mode = rgbtp_pkg::MODE_NUMBER;
        end
      end
      rgbtp_pkg::MODE_NUMBER: begin
        if (is_digit) begin
          nxt.acc = (sum > {3'b000, rgbtp_pkg::AccSat}) ? rgbtp_pkg::AccSat
                                                        : sum[rgbtp_pkg::AccW-1:0];
        end else if (st.acc > rgbtp_pkg::ValueMax) begin
          res.emit = 1'b1;
          nxt.mode = rgbtp_pkg::MODE_IDLE;
        end else if (st.idx < rgbtp_pkg::LastIdx) begin
          if (char_code != rgbtp_pkg::ChComma) begin
            res.emit = 1'b1;
            nxt.mode = rgbtp_pkg::MODE_IDLE;
          end else begin
            nxt.col  = packed_col;
            nxt.idx  = st.idx + 2'd1;
            nxt.acc  = '0;
            nxt.mode = rgbtp_pkg::MODE_AFTER;
          end
        end else begin
          nxt.col    = packed_col;
          nxt.mode   = rgbtp_pkg::MODE_IDLE;
          res.emit   = 1'b1;
          res.ok     = 1'b1;
          res.colour = packed_col;
        end
      end
      default: begin
        nxt.mode = rgbtp_pkg::MODE_IDLE;
      end
    endcase
  end

endmodule

[sim/rgb_triple_text_parser_unit_tb.sv]
// rgb_triple_text_parser_unit_tb: self-checking bench for the rgb triple text parser
// streams characters with bursts and gaps, predicts each parse result, checks every out transfer
// depends on rgbtp_pkg and rgb_triple_text_parser_unit
`timescale 1ns / 1ps

module rgb_triple_text_parser_unit_tb;

  localparam int StallLimit = 5000;
  localparam int HoldCycles = 300;
  localparam int Radix      = 10;
  localparam int RandChars  = 1950;
  localparam int Chunks     = 10;

  typedef struct {
    logic [rgbtp_pkg::CharW-1:0] ch;
    logic                        st;
  } char_item_t;

  typedef struct {
    logic                       ok;
    logic [rgbtp_pkg::ColW-1:0] colour;
  } colour_res_t;

  class colour_scoreboard;
    colour_res_t                want_q[$];
    int                         errors;
    rgbtp_pkg::mode_t           mode;
    logic [rgbtp_pkg::IdxW-1:0] idx;
    logic [rgbtp_pkg::AccW-1:0] acc;
    logic [rgbtp_pkg::ColW-1:0] col;

    function new();
      errors = 0;
      mode   = rgbtp_pkg::MODE_IDLE;
      idx    = '0;
      acc    = '0;
      col    = '0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function void close_parse(logic ok);
      colour_res_t r;
      r.ok     = ok;
      r.colour = col;
      want_q.push_back(r);
      mode = rgbtp_pkg::MODE_IDLE;
    endfunction

    // advance the parse by one accepted character
    function void note_char(logic [rgbtp_pkg::CharW-1:0] c, logic st);
      int   sum;
      logic is_dig;
      logic is_ws;
      is_dig = (c >= rgbtp_pkg::ChZero) && (c <= rgbtp_pkg::ChNine);
      is_ws  = (c == rgbtp_pkg::ChSpace) ||
               ((c >= rgbtp_pkg::ChTab) && (c <= rgbtp_pkg::ChCr));
      if (st) begin
        mode = rgbtp_pkg::MODE_LEAD;
        idx  = '0;
        acc  = '0;
        col  = '0;
      end
      case (mode)
        rgbtp_pkg::MODE_LEAD, rgbtp_pkg::MODE_AFTER: begin
          if (!((mode == rgbtp_pkg::MODE_LEAD) && is_ws)) begin
            if (!is_dig) begin
              close_parse(1'b0);
            end else begin
              acc  = {1'b0, c - rgbtp_pkg::ChZero};
              mode = rgbtp_pkg::MODE_NUMBER;
            end
          end
        end
        rgbtp_pkg::MODE_NUMBER: begin
          if (is_dig) begin
            sum = int'(acc) * Radix + int'(c - rgbtp_pkg::ChZero);
            acc = (sum > int'(rgbtp_pkg::AccSat)) ? rgbtp_pkg::AccSat
                                                  : sum[rgbtp_pkg::AccW-1:0];
          end else if (acc > rgbtp_pkg::ValueMax) begin
            close_parse(1'b0);
          end else if (idx < rgbtp_pkg::LastIdx) begin
            if (c != rgbtp_pkg::ChComma) begin
              close_parse(1'b0);
            end else begin
              col  = {col[rgbtp_pkg::ColW-9:0], acc[7:0]};
              idx  = idx + 1'b1;
              acc  = '0;
              mode = rgbtp_pkg::MODE_AFTER;
            end
          end else begin
            col = {col[rgbtp_pkg::ColW-9:0], acc[7:0]};
            close_parse(1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic ok, logic [rgbtp_pkg::ColW-1:0] colour);
      colour_res_t w;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual ok=%0b colour=%06h",
                 $time, ok, colour);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (ok !== w.ok) begin
        $display("%0t: ok mismatch, expected %0b, actual %0b", $time, w.ok, ok);
        errors++;
      end
      if (colour !== w.colour) begin
        $display("%0t: colour mismatch, expected %06h, actual %06h", $time, w.colour, colour);
        errors++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [rgbtp_pkg::CharW-1:0] in_char_code = '0;
  logic                        in_start_req = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        out_ok;
  logic [rgbtp_pkg::ColW-1:0]  out_colour;

  colour_scoreboard sb;
  char_item_t       stim_q[$];
  char_item_t       build_q[$];
  int               hold_reqs = 0;
  int               holds_done = 0;

  rgb_triple_text_parser_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_start_req (in_start_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_ok       (out_ok),
    .out_colour   (out_colour)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [rgbtp_pkg::CharW-1:0] space_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? rgbtp_pkg::ChSpace : rgbtp_pkg::ChTab + rgbtp_pkg::CharW'(r);
  endfunction

  function automatic logic [rgbtp_pkg::CharW-1:0] rand_nondigit();
    logic [rgbtp_pkg::CharW-1:0] c;
    c = rgbtp_pkg::CharW'($urandom_range(0, 255));
    while ((c >= rgbtp_pkg::ChZero) && (c <= rgbtp_pkg::ChNine))
      c = rgbtp_pkg::CharW'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic push_build(logic [rgbtp_pkg::CharW-1:0] c, logic st);
    char_item_t it;
    it.ch = c;
    it.st = st;
    build_q.push_back(it);
  endtask

  task automatic push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) push_build(s[i], i == 0);
    while (build_q.size() > 0) stim_q.push_back(build_q.pop_front());
  endtask

  task automatic add_number();
    int                          kind;
    int                          val;
    int                          nz;
    int                          i;
    logic [rgbtp_pkg::CharW-1:0] digs[$];
    kind = $urandom_range(0, 15);
    val  = $urandom_range(0, 255);
    case (kind)
      0: return;
      1: val = $urandom_range(256, 999);
      2: begin
        nz = $urandom_range(4, 7);
        for (i = 0; i < nz; i++)
          push_build(rgbtp_pkg::ChZero + rgbtp_pkg::CharW'($urandom_range(0, 9)), 1'b0);
        return;
      end
      3: val = 255;
      4: val = 0;
      5: val = 256;
      default: ;
    endcase
    do begin
      digs.push_front(rgbtp_pkg::ChZero + rgbtp_pkg::CharW'(val % Radix));
      val = val / Radix;
    end while (val > 0);
    nz = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    for (i = 0; i < nz; i++) push_build(rgbtp_pkg::ChZero, 1'b0);
    foreach (digs[k]) push_build(digs[k], 1'b0);
  endtask

  // one start-led triple with random content, sometimes malformed or cut short
  task automatic add_triple();
    int f;
    int n;
    int r;
    build_q = {};
    n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    repeat (n) push_build(space_char(), 1'b0);
    for (f = 0; f < 3; f++) begin
      add_number();
      if (f < 2) begin
        r = $urandom_range(0, 15);
        if (r == 0) begin
          push_build(rand_nondigit(), 1'b0);
        end else if (r == 1) begin
          push_build(rgbtp_pkg::ChComma, 1'b0);
          push_build(space_char(), 1'b0);
        end else begin
          push_build(rgbtp_pkg::ChComma, 1'b0);
        end
      end
    end
    case ($urandom_range(0, 3))
      0: push_build('0, 1'b0);
      1: push_build(space_char(), 1'b0);
      2: push_build(rgbtp_pkg::ChComma, 1'b0);
      default: push_build(rand_nondigit(), 1'b0);
    endcase
    n = $urandom_range(0, 3);
    repeat (n) push_build(rgbtp_pkg::CharW'($urandom_range(0, 255)), 1'b0);
    build_q[0].st = 1'b1;
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, build_q.size());
      while (build_q.size() > n) void'(build_q.pop_back());
    end
    while (build_q.size() > 0) stim_q.push_back(build_q.pop_front());
  endtask

  task automatic add_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      push_build(rgbtp_pkg::CharW'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      stim_q.push_back(build_q.pop_front());
    end
  endtask

  task automatic send_char(logic [rgbtp_pkg::CharW-1:0] c, logic st);
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_start_req <= st;
    do @(posedge clk); while (!in_ready);
    sb.note_char(c, st);
  endtask

  task automatic stream_chars();
    char_item_t it;
    int         burst;
    int         gap;
    burst = $urandom_range(1, 40);
    while (stim_q.size() > 0) begin
      it = stim_q.pop_front();
      send_char(it.ch, it.st);
      burst--;
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // receiver: styled stall patterns plus long hold-offs on request
  initial begin : rx_side
    int style;
    int left;
    int hold;
    int cyc;
    style = 0;
    left  = 0;
    hold  = 0;
    cyc   = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (out_valid === 1'b1 && out_ready === 1'b1) sb.check_result(out_ok, out_colour);
      if (hold == 0 && hold_reqs != holds_done) begin
        hold = HoldCycles;
        holds_done++;
      end
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left  = $urandom_range(16, 96);
      end
      left--;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= (cyc % 5 < 2);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid === 1'b1 && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : main
    int chunk;
    int target;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: whitespace lead, extremes, out-of-range value, missing digit and comma, nul end
    push_text("\t255,0,7x");
    push_text("256,");
    push_text("1,,");
    push_text("-");
    push_text("3;");
    push_text("0,0,0");
    push_build('0, 1'b0);
    stim_q.push_back(build_q.pop_front());
    stream_chars();
    drain_results();

    for (chunk = 0; chunk < Chunks; chunk++) begin
      target = RandChars / Chunks;
      while (stim_q.size() < target) begin
        if ($urandom_range(0, 9) == 0) add_noise();
        else add_triple();
      end
      if (chunk == 3) hold_reqs++;
      stream_chars();
      if (chunk == 6) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/rgbtp_pkg.sv
design/rgbtp_step.sv
design/rgb_triple_text_parser_unit.sv
sim/rgb_triple_text_parser_unit_tb.sv
